>>> design/ppu_pkg.sv
// ppu_pkg: widths, register indexes and beat types for the point projection unit
// no dependencies
`default_nettype none
package ppu_pkg;

   localparam int COORD_WIDTH = 20;
   localparam int PIXEL_WIDTH = 24;

   localparam int BIG_CW    = (COORD_WIDTH > 20) ? COORD_WIDTH : 20;
   localparam int CAM_SHIFT = BIG_CW - 12;

   localparam int ROT_W  = 16;
   localparam int INTR_W = 20;
   localparam int CAM_W  = 20;

   localparam int D_W    = BIG_CW + 1;
   localparam int P1_W   = ROT_W + D_W;
   localparam int ACC1_W = P1_W + 2;
   localparam int C_W    = ACC1_W - CAM_SHIFT;
   localparam int P2_W   = INTR_W + C_W;
   localparam int T_W    = P2_W + 2;

   localparam int MAG_W  = T_W;
   localparam int UN_W   = MAG_W + 9;
   localparam int Q_W    = PIXEL_WIDTH;
   localparam int DS_W   = MAG_W + Q_W;

   localparam int XF_STAGES = 5;
   localparam int ST_MAG    = XF_STAGES;
   localparam int ST_PREP   = XF_STAGES + 1;
   localparam int ST_DIV0   = XF_STAGES + 2;
   localparam int ST_OUT    = ST_DIV0 + Q_W;
   localparam int NST       = ST_OUT + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;

   localparam logic [CSR_IDX_W-1:0] REG_ROT0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTR0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTR1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTR2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CAM   = 3'd6;

   localparam logic signed [Q_W-1:0] PIX_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] PIX_MIN = {1'b1, {(Q_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [PIXEL_WIDTH-1:0] pix_u;
      logic signed [PIXEL_WIDTH-1:0] pix_v;
      logic                          zero_depth;
      logic                          clipped;
   } rsp_type;

   typedef struct packed {
      logic [2:0][3*ROT_W-1:0]  rot;
      logic [2:0][3*INTR_W-1:0] intr;
      logic [3*CAM_W-1:0]       cam;
   } cfg_type;

   typedef struct packed {
      logic [UN_W-1:0]  rem;
      logic [MAG_W-1:0] ud;
      logic             neg;
      logic             ovf;
   } div_in_type;

   typedef struct packed {
      logic [Q_W-1:0] q;
      logic           neg;
      logic           ovf;
   } div_out_type;

endpackage
`default_nettype wire

>>> design/pinhole_point_projection_unit.sv
// Pinhole point projection: one world point in, one pixel beat out, every cycle
// unless stalled. The pipeline is 8 + PIXEL_WIDTH stages deep: five of transform,
// then the magnitude and dividend setup stages, one per quotient bit of two parallel
// restoring dividers, then the output register. Stalls propagate back only as far
// as the first empty stage, so a new point is taken while results wait.
// depends on ppu_pkg, ppu_xform, ppu_div
`default_nettype none
module pinhole_point_projection_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire ppu_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output ppu_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [ppu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ppu_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ppu_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic [NST-1:0] v_ff, v_in, en;
   logic           out_free;

   logic signed [T_W-1:0] t0, t1, t2;
   logic [MAG_W-1:0] mu_ff, mv_ff, md_ff;
   logic             negu_ff, negv_ff, zero_ff;
   div_in_type       du_ff, dv_ff, du_in, dv_in;
   logic             zprep_ff;
   logic             zp_ff [Q_W];
   div_out_type      qu, qv;
   rsp_type          rsp_ff, rsp_in;
   logic signed [Q_W-1:0] u_val, v_val;
   logic             u_sat, v_sat;

   // configuration
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ROT0:  cfg_in.rot[0]  = csr_wdata[3*ROT_W-1:0];
            REG_ROT1:  cfg_in.rot[1]  = csr_wdata[3*ROT_W-1:0];
            REG_ROT2:  cfg_in.rot[2]  = csr_wdata[3*ROT_W-1:0];
            REG_INTR0: cfg_in.intr[0] = csr_wdata[3*INTR_W-1:0];
            REG_INTR1: cfg_in.intr[1] = csr_wdata[3*INTR_W-1:0];
            REG_INTR2: cfg_in.intr[2] = csr_wdata[3*INTR_W-1:0];
            REG_CAM:   cfg_in.cam     = csr_wdata[3*CAM_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot[0]  <= (3*ROT_W)'(16384);
         cfg_ff.rot[1]  <= (3*ROT_W)'(16384) << ROT_W;
         cfg_ff.rot[2]  <= (3*ROT_W)'(16384) << (2*ROT_W);
         cfg_ff.intr[0] <= (3*INTR_W)'(256);
         cfg_ff.intr[1] <= (3*INTR_W)'(256) << INTR_W;
         cfg_ff.intr[2] <= (3*INTR_W)'(256) << (2*INTR_W);
         cfg_ff.cam     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage enables: a stage moves when rsp_ready is high or any stage at or after it is empty
   always_comb begin
      out_free = !v_ff[NST-1] || rsp_ready;
      for (int i = 0; i < NST; i++) begin
         en[i] = out_free || (|(~v_ff & ({NST{1'b1}} << i)));
      end
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int i = 1; i < NST; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];

   ppu_xform u_xform (
      .clock    (clock),
      .en       (en[XF_STAGES-1:0]),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .t0       (t0),
      .t1       (t1),
      .t2       (t2)
   );

   // magnitudes and signs
   always_ff @(posedge clock) begin
      if (en[ST_MAG]) begin
         mu_ff   <= t0[T_W-1] ? MAG_W'(-t0) : MAG_W'(t0);
         mv_ff   <= t1[T_W-1] ? MAG_W'(-t1) : MAG_W'(t1);
         md_ff   <= t2[T_W-1] ? MAG_W'(-t2) : MAG_W'(t2);
         negu_ff <= t0[T_W-1] ^ t2[T_W-1];
         negv_ff <= t1[T_W-1] ^ t2[T_W-1];
         zero_ff <= (t2 == '0);
      end
   end

   // rounded dividend and quotient overflow
   always_comb begin
      du_in.rem = (UN_W'(mu_ff) << 8) + UN_W'(md_ff >> 1);
      dv_in.rem = (UN_W'(mv_ff) << 8) + UN_W'(md_ff >> 1);
      du_in.ud  = md_ff;
      dv_in.ud  = md_ff;
      du_in.neg = negu_ff;
      dv_in.neg = negv_ff;
      du_in.ovf = DS_W'(du_in.rem) >= (DS_W'(md_ff) << Q_W);
      dv_in.ovf = DS_W'(dv_in.rem) >= (DS_W'(md_ff) << Q_W);
   end

   always_ff @(posedge clock) begin
      if (en[ST_PREP]) begin
         du_ff    <= du_in;
         dv_ff    <= dv_in;
         zprep_ff <= zero_ff;
      end
      for (int k = 0; k < Q_W; k++) begin
         if (en[ST_DIV0+k]) zp_ff[k] <= (k == 0) ? zprep_ff : zp_ff[(k == 0) ? 0 : k-1];
      end
   end

   ppu_div u_div_u (
      .clock (clock),
      .en    (en[ST_DIV0 +: Q_W]),
      .din   (du_ff),
      .dout  (qu)
   );

   ppu_div u_div_v (
      .clock (clock),
      .en    (en[ST_DIV0 +: Q_W]),
      .din   (dv_ff),
      .dout  (qv)
   );

   // sign, saturation and zero depth
   always_comb begin
      if (qu.neg) begin
         u_sat = qu.ovf || (qu.q > Q_W'(PIX_MIN));
         u_val = u_sat ? PIX_MIN : -$signed(qu.q);
      end else begin
         u_sat = qu.ovf || qu.q[Q_W-1];
         u_val = u_sat ? PIX_MAX : $signed(qu.q);
      end
      if (qv.neg) begin
         v_sat = qv.ovf || (qv.q > Q_W'(PIX_MIN));
         v_val = v_sat ? PIX_MIN : -$signed(qv.q);
      end else begin
         v_sat = qv.ovf || qv.q[Q_W-1];
         v_val = v_sat ? PIX_MAX : $signed(qv.q);
      end
      if (zp_ff[Q_W-1]) begin
         rsp_in.pix_u      = '0;
         rsp_in.pix_v      = '0;
         rsp_in.zero_depth = 1'b1;
         rsp_in.clipped    = 1'b0;
      end else begin
         rsp_in.pix_u      = u_val;
         rsp_in.pix_v      = v_val;
         rsp_in.zero_depth = 1'b0;
         rsp_in.clipped    = u_sat || v_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = v_ff[NST-1];
   assign rsp_data  = rsp_ff;

   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_depth |->
         rsp_data.pix_u == '0 && rsp_data.pix_v == '0 && !rsp_data.clipped)
      else $error("zero depth beat with nonzero payload");

   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |->
         rsp_data.pix_u == PIX_MAX || rsp_data.pix_u == PIX_MIN ||
         rsp_data.pix_v == PIX_MAX || rsp_data.pix_v == PIX_MIN)
      else $error("clipped beat without a saturated coordinate");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !v_ff[NST-1] |-> req_ready)
      else $error("input stalled with empty output stage");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule
`default_nettype wire

>>> design/ppu_xform.sv
// ppu_xform: camera offset, rotation and intrinsic transform, five register stages
// depends on ppu_pkg
`default_nettype none
module ppu_xform (
   input  wire logic                                  clock,
   input  wire logic [ppu_pkg::XF_STAGES-1:0]         en,
   input  wire ppu_pkg::cfg_type                      cfg,
   input  wire ppu_pkg::req_type                      req_data,
   output logic signed [ppu_pkg::T_W-1:0]             t0,
   output logic signed [ppu_pkg::T_W-1:0]             t1,
   output logic signed [ppu_pkg::T_W-1:0]             t2
);
   import ppu_pkg::*;

   logic signed [D_W-1:0]  d_ff  [3];
   logic signed [D_W-1:0]  d_in  [3];
   logic signed [P1_W-1:0] p1_ff [3][3];
   logic signed [P1_W-1:0] p1_in [3][3];
   logic signed [C_W-1:0]  c_ff  [3];
   logic signed [C_W-1:0]  c_in  [3];
   logic signed [P2_W-1:0] p2_ff [3][3];
   logic signed [P2_W-1:0] p2_in [3][3];
   logic signed [T_W-1:0]  t_ff  [3];
   logic signed [T_W-1:0]  t_in  [3];

   logic signed [COORD_WIDTH-1:0] pt [3];
   logic signed [ACC1_W-1:0]      acc1;

   always_comb begin
      pt[0] = req_data.point_x;
      pt[1] = req_data.point_y;
      pt[2] = req_data.point_z;
      for (int k = 0; k < 3; k++) begin
         d_in[k] = D_W'(pt[k]) - D_W'($signed(cfg.cam[CAM_W*k +: CAM_W]));
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            p1_in[r][k] = P1_W'($signed(cfg.rot[r][ROT_W*k +: ROT_W])) * P1_W'(d_ff[k]);
            p2_in[r][k] = P2_W'($signed(cfg.intr[r][INTR_W*k +: INTR_W])) * P2_W'(c_ff[k]);
         end
      end
      acc1 = '0;
      for (int r = 0; r < 3; r++) begin
         acc1    = ACC1_W'(p1_ff[r][0]) + ACC1_W'(p1_ff[r][1]) + ACC1_W'(p1_ff[r][2])
                   + (ACC1_W'(1) <<< (CAM_SHIFT - 1));
         c_in[r] = C_W'(acc1 >>> CAM_SHIFT);
         t_in[r] = T_W'(p2_ff[r][0]) + T_W'(p2_ff[r][1]) + T_W'(p2_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         if (en[0]) d_ff[r] <= d_in[r];
         if (en[2]) c_ff[r] <= c_in[r];
         if (en[4]) t_ff[r] <= t_in[r];
         for (int k = 0; k < 3; k++) begin
            if (en[1]) p1_ff[r][k] <= p1_in[r][k];
            if (en[3]) p2_ff[r][k] <= p2_in[r][k];
         end
      end
   end

   assign t0 = t_ff[0];
   assign t1 = t_ff[1];
   assign t2 = t_ff[2];

endmodule
`default_nettype wire

>>> design/ppu_div.sv
// ppu_div: pipelined restoring divider, one quotient bit per register stage
// depends on ppu_pkg
`default_nettype none
module ppu_div (
   input  wire logic                     clock,
   input  wire logic [ppu_pkg::Q_W-1:0]  en,
   input  wire ppu_pkg::div_in_type      din,
   output ppu_pkg::div_out_type          dout
);
   import ppu_pkg::*;

   logic [UN_W-1:0]  rem_ff [Q_W];
   logic [MAG_W-1:0] ud_ff  [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic             neg_ff [Q_W];
   logic             ovf_ff [Q_W];

   logic [UN_W-1:0]  rem_src [Q_W];
   logic [MAG_W-1:0] ud_src  [Q_W];
   logic [Q_W-1:0]   q_src   [Q_W];
   logic [UN_W-1:0]  rem_in  [Q_W];
   logic [Q_W-1:0]   q_in    [Q_W];
   logic [DS_W-1:0]  dsh     [Q_W];
   logic             ge      [Q_W];

   always_comb begin
      for (int k = 0; k < Q_W; k++) begin
         rem_src[k] = (k == 0) ? din.rem : rem_ff[(k == 0) ? 0 : k-1];
         ud_src[k]  = (k == 0) ? din.ud  : ud_ff[(k == 0) ? 0 : k-1];
         q_src[k]   = (k == 0) ? '0      : q_ff[(k == 0) ? 0 : k-1];
         dsh[k]     = DS_W'(ud_src[k]) << (Q_W - 1 - k);
         ge[k]      = DS_W'(rem_src[k]) >= dsh[k];
         rem_in[k]  = ge[k] ? UN_W'(DS_W'(rem_src[k]) - dsh[k]) : rem_src[k];
         q_in[k]    = q_src[k];
         q_in[k][Q_W-1-k] = ge[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Q_W; k++) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            ud_ff[k]  <= ud_src[k];
            q_ff[k]   <= q_in[k];
            neg_ff[k] <= (k == 0) ? din.neg : neg_ff[(k == 0) ? 0 : k-1];
            ovf_ff[k] <= (k == 0) ? din.ovf : ovf_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign dout.q   = q_ff[Q_W-1];
   assign dout.neg = neg_ff[Q_W-1];
   assign dout.ovf = ovf_ff[Q_W-1];

endmodule
`default_nettype wire
